// ===== hdl/utf8ss_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8ss_pkg
// Shared types, constants and helpers for the UTF-8 character segmenter.
// ----------------------------------------------------------------------------
package utf8ss_pkg;

   localparam int INDEX_BITS = 24;
   localparam int NEED_BITS  = 3;

   localparam logic [7:0]            CONT_MASK = 8'hC0;
   localparam logic [7:0]            CONT_TAG  = 8'h80;
   localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;

   typedef enum logic [1:0] {
      KIND_SINGLE,
      KIND_CONT,
      KIND_LEAD
   } kind_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic [7:0]            out_byte;
      logic [INDEX_BITS-1:0] char_index;
      logic                  first_of_char;
      logic                  in_range;
      logic                  run_last;
      logic                  string_done;
      logic [INDEX_BITS-1:0] char_total;
   } rsp_type;

   // classified byte as queued between front and back
   typedef struct packed {
      logic [7:0]           data;
      logic                 eos;
      kind_type             kind;
      logic [NEED_BITS-1:0] need;
   } item_type;

   function automatic logic [3:0] lead_ones(input logic [7:0] b);
      logic       run;
      logic [3:0] n;
      run = 1'b1;
      n   = 4'd0;
      for (int i = 7; i >= 0; i--) begin
         if (run && b[i]) begin
            n = n + 4'd1;
         end else begin
            run = 1'b0;
         end
      end
      return n;
   endfunction

endpackage

// ===== hdl/utf8_char_segment_substring.sv =====
// ----------------------------------------------------------------------------
// utf8_char_segment_substring
// Lenient UTF-8 character segmenter with substring range tagging.
// Path: a closing or breaking byte passes the queue register, then the release list
//    register, before rsp; bytes of an open sequence wait for the byte that ends it.
// Throughput: one byte per cycle while rsp_ready is high and no character is longer
//    than the release before it; a longer character leaves rsp idle while it gathers.
// Reset empties the open sequence and queue, clears the character counter and start register, and sets end to all ones.
// ----------------------------------------------------------------------------
module utf8_char_segment_substring #(
   parameter int MAX_SEQ_BYTES = 6,
   parameter int QUEUE_DEPTH   = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  utf8ss_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output utf8ss_pkg::rsp_type rsp_data,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   localparam int IW = utf8ss_pkg::INDEX_BITS;
   localparam logic REG_START = 1'b0;
   localparam logic REG_END   = 1'b1;

   logic [IW-1:0] start_ff;
   logic [IW-1:0] end_ff;
   logic          wr_en;

   utf8ss_pkg::item_type push_item;
   utf8ss_pkg::item_type head_item;
   logic                 push, push_ready;
   logic                 head_valid, pop;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;
   assign prdata = (paddr[2] == REG_END) ? 32'(end_ff) : 32'(start_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         end_ff   <= '1;
      end else if (wr_en) begin
         if (paddr[2] == REG_START) begin
            start_ff <= pwdata[IW-1:0];
         end else begin
            end_ff <= pwdata[IW-1:0];
         end
      end
   end

   utf8ss_front #(
      .MAX_SEQ_BYTES(MAX_SEQ_BYTES)
   ) u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .push      (push),
      .push_item (push_item),
      .push_ready(push_ready)
   );

   utf8ss_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .push_ready(push_ready),
      .pop       (pop),
      .head_valid(head_valid),
      .head_item (head_item)
   );

   utf8ss_back #(
      .MAX_SEQ_BYTES(MAX_SEQ_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (head_valid),
      .q_item    (head_item),
      .q_pop     (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .start_char(start_ff),
      .end_char  (end_ff)
   );

endmodule

// ===== hdl/utf8ss_queue.sv =====
// ----------------------------------------------------------------------------
// utf8ss_queue
// Short FIFO of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
module utf8ss_queue #(
   parameter int DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  utf8ss_pkg::item_type  push_item,
   output logic                  push_ready,
   input  logic                  pop,
   output logic                  head_valid,
   output utf8ss_pkg::item_type  head_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   utf8ss_pkg::item_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== hdl/utf8ss_front.sv =====
// ----------------------------------------------------------------------------
// utf8ss_front
// Accepts input beats and classifies each byte by its leading ones.
// ----------------------------------------------------------------------------
module utf8ss_front #(
   parameter int MAX_SEQ_BYTES = 6
) (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  utf8ss_pkg::req_type  req_data,
   output logic                 push,
   output utf8ss_pkg::item_type push_item,
   input  logic                 push_ready
);

   logic [3:0] ones;
   logic [3:0] ones_m1;

   assign ones      = utf8ss_pkg::lead_ones(req_data.in_byte);
   assign ones_m1   = ones - 4'd1;
   assign req_ready = push_ready;
   assign push      = req_valid && push_ready;

   always_comb begin
      push_item.data = req_data.in_byte;
      push_item.eos  = req_data.end_of_string;
      push_item.need = '0;
      push_item.kind = utf8ss_pkg::KIND_SINGLE;
      if ((req_data.in_byte & utf8ss_pkg::CONT_MASK) == utf8ss_pkg::CONT_TAG) begin
         push_item.kind = utf8ss_pkg::KIND_CONT;
      end else if (ones >= 4'd2 && ones <= 4'(MAX_SEQ_BYTES)) begin
         push_item.kind = utf8ss_pkg::KIND_LEAD;
         push_item.need = ones_m1[utf8ss_pkg::NEED_BITS-1:0];
      end
   end

endmodule

// ===== hdl/utf8ss_back.sv =====
// ----------------------------------------------------------------------------
// utf8ss_back
// Holds open sequences, builds release lists and emits one beat per cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
module utf8ss_back #(
   parameter int MAX_SEQ_BYTES = 6
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  q_valid,
   input  utf8ss_pkg::item_type                  q_item,
   output logic                                  q_pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output utf8ss_pkg::rsp_type                   rsp_data,
   input  logic [utf8ss_pkg::INDEX_BITS-1:0]     start_char,
   input  logic [utf8ss_pkg::INDEX_BITS-1:0]     end_char
);

   localparam int CNT_W = $clog2(MAX_SEQ_BYTES + 1);
   localparam int PTR_W = $clog2(MAX_SEQ_BYTES);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SEQ_BYTES);
   localparam int IW = utf8ss_pkg::INDEX_BITS;
   localparam int NW = utf8ss_pkg::NEED_BITS;

   // open sequence
   logic [7:0]       held_ff [MAX_SEQ_BYTES];
   logic [7:0]       held_in [MAX_SEQ_BYTES];
   logic [CNT_W-1:0] held_cnt_ff, held_cnt_in;
   logic [NW-1:0]    need_ff, need_in;

   // release list being emitted
   logic [7:0]       list_ff [MAX_SEQ_BYTES];
   logic [CNT_W-1:0] list_cnt_ff, list_cnt_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic             list_v_ff, list_v_in;
   logic             whole_ff, whole_in;
   logic             eos_ff, eos_in;
   logic [IW-1:0]    idx_ff, idx_in;

   logic [7:0]       tmp [MAX_SEQ_BYTES];
   logic [CNT_W-1:0] emit_cnt;
   logic             emit_whole;
   logic             cont_ok;
   logic             load;
   logic [CNT_W-1:0] cnt_m1;
   logic             last;
   logic             fire;
   logic             first;
   logic             bump;
   logic [IW-1:0]    idx_inc;
   logic [IW-1:0]    next_idx;
   logic             done;

   assign cont_ok = (need_ff != '0) && (q_item.kind == utf8ss_pkg::KIND_CONT)
                    && (held_cnt_ff < MAX_CNT);

   always_comb begin
      for (int i = 0; i < MAX_SEQ_BYTES; i++) begin
         tmp[i] = (held_cnt_ff == CNT_W'(i)) ? q_item.data : held_ff[i];
      end
   end

   always_comb begin
      emit_cnt    = held_cnt_ff + 1'b1;
      emit_whole  = 1'b0;
      held_cnt_in = '0;
      need_in     = '0;
      held_in     = held_ff;
      if (cont_ok) begin
         if (need_ff == NW'(1)) begin
            emit_whole = 1'b1;
         end else if (!q_item.eos) begin
            emit_cnt    = '0;
            held_cnt_in = held_cnt_ff + 1'b1;
            need_in     = need_ff - 1'b1;
            held_in     = tmp;
         end
      end else if (q_item.kind == utf8ss_pkg::KIND_LEAD && !q_item.eos) begin
         emit_cnt    = held_cnt_ff;
         held_cnt_in = CNT_W'(1);
         need_in     = q_item.need;
         held_in[0]  = q_item.data;
      end
   end

   assign cnt_m1    = list_cnt_ff - 1'b1;
   assign last      = (ptr_ff == cnt_m1[PTR_W-1:0]);
   assign rsp_valid = list_v_ff;
   assign fire      = list_v_ff && rsp_ready;
   // bytes that only extend the open sequence do not need the emitter
   assign q_pop     = q_valid && (!list_v_ff || (rsp_ready && last) || (emit_cnt == '0));
   assign load      = q_pop && (emit_cnt != '0);

   assign first    = !whole_ff || (ptr_ff == '0);
   assign bump     = !whole_ff || last;
   assign idx_inc  = (idx_ff == utf8ss_pkg::INDEX_MAX) ? idx_ff : idx_ff + 1'b1;
   assign next_idx = bump ? idx_inc : idx_ff;
   assign done     = eos_ff && last;

   always_comb begin
      rsp_data.out_byte      = list_ff[ptr_ff];
      rsp_data.char_index    = idx_ff;
      rsp_data.first_of_char = first;
      rsp_data.in_range      = (idx_ff >= start_char) && (idx_ff < end_char);
      rsp_data.run_last      = last;
      rsp_data.string_done   = done;
      rsp_data.char_total    = done ? next_idx : '0;
   end

   always_comb begin
      list_v_in   = list_v_ff;
      ptr_in      = ptr_ff;
      idx_in      = idx_ff;
      list_cnt_in = list_cnt_ff;
      whole_in    = whole_ff;
      eos_in      = eos_ff;
      if (fire) begin
         if (last) begin
            list_v_in = 1'b0;
            idx_in    = eos_ff ? '0 : next_idx;
         end else begin
            ptr_in = ptr_ff + 1'b1;
            idx_in = next_idx;
         end
      end
      if (load) begin
         list_v_in   = 1'b1;
         ptr_in      = '0;
         list_cnt_in = emit_cnt;
         whole_in    = emit_whole;
         eos_in      = q_item.eos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_cnt_ff <= '0;
         need_ff     <= '0;
         list_v_ff   <= 1'b0;
         ptr_ff      <= '0;
         idx_ff      <= '0;
         list_cnt_ff <= '0;
         whole_ff    <= 1'b0;
         eos_ff      <= 1'b0;
      end else begin
         list_v_ff   <= list_v_in;
         ptr_ff      <= ptr_in;
         idx_ff      <= idx_in;
         list_cnt_ff <= list_cnt_in;
         whole_ff    <= whole_in;
         eos_ff      <= eos_in;
         if (q_pop) begin
            held_cnt_ff <= held_cnt_in;
            need_ff     <= need_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         held_ff <= held_in;
      end
      if (load) begin
         list_ff <= tmp;
      end
   end

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_cnt_ff <= MAX_CNT)
      else $error("held count exceeds sequence limit");

   a_need_fits: assert property (@(posedge clock) disable iff (reset)
      need_ff != '0 |-> held_cnt_ff != '0
         && (4'(held_cnt_ff) + 4'(need_ff)) <= 4'(MAX_SEQ_BYTES))
      else $error("open sequence longer than limit");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      need_ff == '0 |-> held_cnt_ff == '0)
      else $error("bytes held with no sequence open");

   a_list_cnt: assert property (@(posedge clock) disable iff (reset)
      list_v_ff |-> list_cnt_ff != '0 && list_cnt_ff <= MAX_CNT)
      else $error("release list length out of range");

   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      fire && done |=> idx_ff == '0)
      else $error("character index not cleared after string end");

endmodule

// ===== dv/utf8ss_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8ss_checker
// Watches the byte, result and register ports of the UTF-8 segmenter. It
// groups the accepted bytes into characters with its own copy of the state
// and range registers, queues the tagged bytes each beat should release,
// and compares every result beat field by field against the oldest entry.
// ----------------------------------------------------------------------------
module utf8ss_checker #(
   parameter logic [2:0] START_ADDR = 3'd0,
   parameter logic [2:0] END_ADDR   = 3'd4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  utf8ss_pkg::req_type req_data,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  utf8ss_pkg::rsp_type rsp_data,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   input  logic                pready,
   output int                  fail_count,
   output int                  outstanding
);

   localparam int MAX_SEQ = 6;
   localparam int IW      = utf8ss_pkg::INDEX_BITS;

   logic [7:0]          held_seq [MAX_SEQ];
   int unsigned         held_num;
   int unsigned         conts_left;
   logic [IW-1:0]       char_count;
   logic [IW-1:0]       range_lo;
   logic [IW-1:0]       range_hi;
   utf8ss_pkg::rsp_type tagged_q [$];
   utf8ss_pkg::rsp_type release_q [$];

   task automatic report(input string msg);
      $display("%0t: %s", $time, msg);
      fail_count++;
   endtask

   function automatic int unsigned leading_ones(input logic [7:0] b);
      int unsigned n;
      n = 0;
      while (n < 8 && b[7 - n]) n++;
      return n;
   endfunction

   function automatic void tag_byte(input logic [7:0] b, input logic first);
      utf8ss_pkg::rsp_type r;
      r = '0;
      r.out_byte      = b;
      r.char_index    = char_count;
      r.first_of_char = first;
      r.in_range      = (char_count >= range_lo) && (char_count < range_hi);
      release_q.push_back(r);
   endfunction

   function automatic void count_char();
      if (char_count != utf8ss_pkg::INDEX_MAX) char_count++;
   endfunction

   function automatic void release_each();
      for (int i = 0; i < held_num; i++) begin
         tag_byte(held_seq[i], 1'b1);
         count_char();
      end
      held_num   = 0;
      conts_left = 0;
   endfunction

   function automatic void segment(input utf8ss_pkg::req_type r);
      int unsigned         ones;
      utf8ss_pkg::rsp_type last;
      release_q.delete();
      if (conts_left > 0 && (r.in_byte & utf8ss_pkg::CONT_MASK) == utf8ss_pkg::CONT_TAG
          && held_num < MAX_SEQ) begin
         held_seq[held_num] = r.in_byte;
         held_num++;
         conts_left--;
         if (conts_left == 0) begin
            for (int i = 0; i < held_num; i++) tag_byte(held_seq[i], i == 0);
            count_char();
            held_num = 0;
         end
      end else begin
         if (held_num > 0) release_each();
         ones = leading_ones(r.in_byte);
         if (ones < 2 || ones > MAX_SEQ) begin
            tag_byte(r.in_byte, 1'b1);
            count_char();
         end else begin
            held_seq[0] = r.in_byte;
            held_num    = 1;
            conts_left  = ones - 1;
         end
      end
      if (r.end_of_string) begin
         if (held_num > 0) release_each();
         if (release_q.size() > 0) begin
            last = release_q.pop_back();
            last.string_done = 1'b1;
            last.char_total  = char_count;
            release_q.push_back(last);
         end
         char_count = '0;
      end
      if (release_q.size() > 0) begin
         last = release_q.pop_back();
         last.run_last = 1'b1;
         release_q.push_back(last);
      end
      foreach (release_q[i]) tagged_q.push_back(release_q[i]);
   endfunction

   always @(posedge clock) begin
      utf8ss_pkg::rsp_type want;
      if (reset) begin
         held_num   = 0;
         conts_left = 0;
         char_count = '0;
         range_lo   = '0;
         range_hi   = utf8ss_pkg::INDEX_MAX;
         tagged_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (tagged_q.size() == 0) begin
               report($sformatf("unexpected result beat %h", rsp_data));
            end else begin
               want = tagged_q.pop_front();
               if (rsp_data.out_byte !== want.out_byte)
                  report($sformatf("out_byte %h, want %h", rsp_data.out_byte, want.out_byte));
               if (rsp_data.char_index !== want.char_index)
                  report($sformatf("char_index %0d, want %0d", rsp_data.char_index,
                                   want.char_index));
               if (rsp_data.first_of_char !== want.first_of_char)
                  report($sformatf("first_of_char %b, want %b", rsp_data.first_of_char,
                                   want.first_of_char));
               if (rsp_data.in_range !== want.in_range)
                  report($sformatf("in_range %b, want %b", rsp_data.in_range, want.in_range));
               if (rsp_data.run_last !== want.run_last)
                  report($sformatf("run_last %b, want %b", rsp_data.run_last, want.run_last));
               if (rsp_data.string_done !== want.string_done)
                  report($sformatf("string_done %b, want %b", rsp_data.string_done,
                                   want.string_done));
               if (rsp_data.char_total !== want.char_total)
                  report($sformatf("char_total %0d, want %0d", rsp_data.char_total,
                                   want.char_total));
            end
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr)
               START_ADDR: range_lo = pwdata[IW-1:0];
               END_ADDR:   range_hi = pwdata[IW-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) segment(req_data);
      end
      outstanding = tagged_q.size();
   end

endmodule

// ===== dv/tb_utf8_char_segment_substring.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_char_segment_substring
// Streams strings of well-formed, truncated and stray UTF-8 bytes into the
// segmenter under several substring ranges, with random gaps on the byte
// side and random stalls on the result side. The checker does the scoring.
// ----------------------------------------------------------------------------
module tb_utf8_char_segment_substring;

   localparam logic [2:0] START_ADDR  = 3'd0;
   localparam logic [2:0] END_ADDR    = 3'd4;
   localparam int         TOTAL_BYTES = 170;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   utf8ss_pkg::req_type req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   utf8ss_pkg::rsp_type rsp_data;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [2:0]          paddr = '0;
   logic [31:0]         pwdata = '0;
   logic [31:0]         prdata;
   logic                pready;
   bit                  steady = 1'b0;
   int                  fail_count;
   int                  outstanding;
   int                  sent = 0;
   logic [7:0]          string_bytes [$];

   utf8_char_segment_substring uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   utf8ss_checker #(
      .START_ADDR (START_ADDR),
      .END_ADDR   (END_ADDR)
   ) checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .pready      (pready),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("[utf8_char_segment_substring] ERROR");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   function automatic int pick_gap();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   // result side: random stalls between runs of ready
   initial begin
      int stall;
      @(negedge clock);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   end

   // called and returns at a falling edge; valid stays up for a following beat
   task automatic send_beat(input logic [7:0] b, input logic eos);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{in_byte: b, end_of_string: eos};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
      @(negedge clock);
   endtask

   task automatic send_string_bytes();
      int last;
      last = string_bytes.size() - 1;
      for (int i = 0; i <= last; i++) send_beat(string_bytes[i], i == last);
      string_bytes.delete();
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= addr;
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // drop valid and wait for every expected result
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic settle();
      drain();
      repeat (8) @(negedge clock);
   endtask

   function automatic logic [7:0] cont_byte();
      return 8'h80 | (8'($urandom) & 8'h3F);
   endfunction

   function automatic logic [7:0] lead_byte(input int k);
      return ~(8'hFF >> k) | (8'($urandom) & (8'hFF >> (k + 1)));
   endfunction

   function automatic void add_char(input int k);
      if (k == 1) begin
         string_bytes.push_back(8'($urandom_range(0, 127)));
      end else begin
         string_bytes.push_back(lead_byte(k));
         for (int i = 1; i < k; i++) string_bytes.push_back(cont_byte());
      end
   endfunction

   // truncated sequence, optionally followed by a non-continuation byte
   function automatic void add_broken();
      int         k;
      logic [7:0] b;
      k = $urandom_range(2, 6);
      string_bytes.push_back(lead_byte(k));
      repeat ($urandom_range(0, k - 2)) string_bytes.push_back(cont_byte());
      if ($urandom_range(0, 1)) begin
         b = 8'($urandom);
         if ((b & utf8ss_pkg::CONT_MASK) == utf8ss_pkg::CONT_TAG) b = b ^ 8'h40;
         string_bytes.push_back(b);
      end
   endfunction

   function automatic int pick_width();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 4) return 1;
      if (roll < 6) return 2;
      if (roll < 8) return 3;
      if (roll == 8) return 4;
      return $urandom_range(5, 6);
   endfunction

   function automatic void build_string();
      int roll;
      repeat ($urandom_range(1, 10)) begin
         roll = $urandom_range(0, 99);
         if (roll < 75) add_char(pick_width());
         else if (roll < 90) add_broken();
         else string_bytes.push_back(8'($urandom));
      end
   endfunction

   initial begin
      int phase_base;
      int waited;
      @(negedge clock);
      while (reset) @(negedge clock);

      // singles, lone continuation, FE/FF, complete 2- and 3-byte chars
      string_bytes = '{8'h00, 8'h7F, 8'h80, 8'hFF, 8'hFE, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC};
      send_string_bytes();
      settle();
      csr_write(START_ADDR, 32'd2);
      csr_write(END_ADDR, 32'd9);
      // 6-byte char, broken sequence, string ending mid-sequence
      string_bytes = '{8'hFC, 8'h80, 8'h80, 8'h80, 8'h80, 8'hBF,
                       8'hE2, 8'h82, 8'h41, 8'hF0, 8'h90};
      send_string_bytes();

      for (int phase = 0; sent < TOTAL_BYTES; phase++) begin
         steady = 1'b0;
         settle();
         case (phase)
            0: begin
               csr_write(START_ADDR, 32'hFF00_0000);
               csr_write(END_ADDR, 32'hFFFF_FFFF);
            end
            1: begin
               csr_write(START_ADDR, 32'h00FF_FFFF);
               csr_write(END_ADDR, 32'd0);
            end
            2: begin
               csr_write(START_ADDR, 32'd3);
               csr_write(END_ADDR, 32'd3);
            end
            3: begin
               csr_write(END_ADDR, 32'd4);
               csr_write(START_ADDR, 32'd1);
            end
            default: begin
               csr_write(START_ADDR, ($urandom_range(0, 7) == 0) ? $urandom
                                                               : $urandom_range(0, 12));
               csr_write(END_ADDR, ($urandom_range(0, 7) == 0) ? $urandom
                                                             : $urandom_range(0, 24));
            end
         endcase
         steady = (phase % 4 == 3);
         phase_base = sent;
         while (sent - phase_base < 30) begin
            if ($urandom_range(0, 9) == 0) begin
               drain();
            end
            build_string();
            send_string_bytes();
         end
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      waited = 0;
      while (outstanding != 0 && waited < 100_000) begin
         @(negedge clock);
         waited++;
      end
      repeat (20) @(negedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("[utf8_char_segment_substring] OK");
      end else begin
         $display("[utf8_char_segment_substring] ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/utf8ss_pkg.sv
hdl/utf8ss_queue.sv
hdl/utf8ss_front.sv
hdl/utf8ss_back.sv
hdl/utf8_char_segment_substring.sv
dv/utf8ss_checker.sv
dv/tb_utf8_char_segment_substring.sv
